// File: rtl/lsts_pkg.sv
// Package for the longest-run-with-target-sum block.
// Shared constants and the back-end status type; no dependencies.
package lsts_pkg;

    localparam int TGT_W = 26;  // target register width
    localparam int LEN_W = 11;  // result length width
    localparam int EP_W  = 4;   // table epoch tag width

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_bstat;

endpackage

// File: rtl/lsts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/lsts_front.sv
// Front end: accepts elements, keeps the prefix sum and index, classifies each word.
// Uses lsts_pkg; feeds lsts_queue.
module lsts_front #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [VALUE_BITS-1:0] i_element_value,
    input  logic                        i_is_last,
    input  logic [lsts_pkg::TGT_W-1:0]  i_target,
    input  logic                        i_q_full,
    output logic                        o_push,
    output logic [5+$clog2(MAX_ELEMENTS)+2*(VALUE_BITS+$clog2(MAX_ELEMENTS))-1:0] o_push_data
);
    localparam int POS_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W = VALUE_BITS + POS_W;
    localparam int REM_W = ((SUM_W > lsts_pkg::TGT_W) ? SUM_W : lsts_pkg::TGT_W) + 1;
    localparam logic [CNT_W-1:0] MAX_L = CNT_W'(MAX_ELEMENTS);

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0] new_sum;
    logic [REM_W-1:0] rem;
    logic             ignore;
    logic             rem_inr;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign ignore     = (r_cnt == MAX_L);

    assign new_sum = r_sum + {{(SUM_W-VALUE_BITS){i_element_value[VALUE_BITS-1]}},
                              i_element_value};
    assign rem = {{(REM_W-SUM_W){new_sum[SUM_W-1]}}, new_sum}
               - {{(REM_W-lsts_pkg::TGT_W){i_target[lsts_pkg::TGT_W-1]}}, i_target};
    assign rem_inr = (&rem[REM_W-1:SUM_W-1]) || !(|rem[REM_W-1:SUM_W-1]);

    assign o_push_data = {i_is_last, ignore, (rem == '0), rem_inr, (new_sum == '0),
                          r_cnt[POS_W-1:0], new_sum, rem[SUM_W-1:0]};

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_is_last) begin
                n_sum = '0;
                n_cnt = '0;
            end else if (!ignore) begin
                n_sum = new_sum;
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end
endmodule

// File: rtl/lsts_queue.sv
// Two-entry queue between front and back ends.
// No dependencies.
module lsts_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic [1:0]       o_count
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, do_pop};
        end
    end
endmodule

// File: rtl/lsts_back.sv
// Back end: hashed first-occurrence table with linear probing, best length, result.
// Uses lsts_pkg and lsts_ram; reads words from lsts_queue.
module lsts_back #(
    parameter int MAX_ELEMENTS  = 1024,
    parameter int TABLE_ENTRIES = 1024,
    parameter int VALUE_BITS    = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  logic [5+$clog2(MAX_ELEMENTS)+2*(VALUE_BITS+$clog2(MAX_ELEMENTS))-1:0] i_q_data,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lsts_pkg::LEN_W-1:0]  o_longest_length,
    output logic                        o_overflowed,
    output lsts_pkg::t_bstat            o_stat
);
    localparam int POS_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W = VALUE_BITS + POS_W;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int RW    = lsts_pkg::EP_W + SUM_W + POS_W;
    localparam int MW    = (CNT_W > lsts_pkg::LEN_W) ? CNT_W : lsts_pkg::LEN_W;
    localparam logic [IDX_W:0]   TE_L  = (IDX_W+1)'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] TE_M1 = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [MW-1:0]    LEN_SAT = MW'((1 << lsts_pkg::LEN_W) - 1);

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_PRB  = 5'b00100,
        S_CHK  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic             last;
        logic             ignore;
        logic             rem_zero;
        logic             rem_inr;
        logic             sum_zero;
        logic [POS_W-1:0] idx;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] rem_key;
    } t_item;

    function automatic logic [IDX_W-1:0] f_hash(input logic [SUM_W-1:0] k);
        logic [IDX_W-1:0] h;
        logic [IDX_W:0]   e;
        h = '0;
        for (int i = 0; i < SUM_W; i++) begin
            h[i % IDX_W] = h[i % IDX_W] ^ k[i];
        end
        e = {1'b0, h};
        if (e >= TE_L) begin
            e = e - TE_L;
        end
        return e[IDX_W-1:0];
    endfunction

    t_item q_item;
    assign q_item = t_item'(i_q_data);

    t_state                  r_state, n_state;
    logic [lsts_pkg::EP_W-1:0] r_ep, n_ep;
    logic [IDX_W-1:0]        r_addr, n_addr;
    logic [IDX_W:0]          r_nprb, n_nprb;
    logic                    r_phase, n_phase;
    logic [CNT_W-1:0]        r_best, n_best;
    logic                    r_ovf, n_ovf;
    logic                    r_last, n_last;
    logic [POS_W-1:0]        r_idx, n_idx;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic                    r_sum_zero, n_sum_zero;
    logic [SUM_W-1:0]        r_key, n_key;
    logic                    r_oval, n_oval;
    logic [lsts_pkg::LEN_W-1:0] r_olen, n_olen;
    logic                    r_oovf, n_oovf;

    logic                    ram_we, ram_re;
    logic [IDX_W-1:0]        ram_waddr;
    logic [RW-1:0]           ram_wdata, ram_rdata;
    logic [lsts_pkg::EP_W-1:0] rd_tag;
    logic [SUM_W-1:0]        rd_key;
    logic [POS_W-1:0]        rd_pos;
    logic                    rd_live, rd_hit;
    logic [CNT_W-1:0]        cand;
    logic [MW-1:0]           best_w;
    logic [IDX_W-1:0]        nxt_addr;

    lsts_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_tag   = ram_rdata[RW-1 -: lsts_pkg::EP_W];
    assign rd_key   = ram_rdata[POS_W +: SUM_W];
    assign rd_pos   = ram_rdata[POS_W-1:0];
    assign rd_live  = (rd_tag == r_ep);
    assign rd_hit   = rd_live && (rd_key == r_key);
    assign cand     = CNT_W'(r_idx - rd_pos);
    assign best_w   = MW'(r_best);
    assign nxt_addr = (r_addr == TE_M1) ? '0 : r_addr + 1'b1;

    assign o_out_valid      = r_oval;
    assign o_longest_length = r_olen;
    assign o_overflowed     = r_oovf;
    assign o_stat.clearing  = (r_state == S_CLR);
    assign o_stat.busy      = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_ep       = r_ep;
        n_addr     = r_addr;
        n_nprb     = r_nprb;
        n_phase    = r_phase;
        n_best     = r_best;
        n_ovf      = r_ovf;
        n_last     = r_last;
        n_idx      = r_idx;
        n_sum      = r_sum;
        n_sum_zero = r_sum_zero;
        n_key      = r_key;
        n_oval     = r_oval && i_out_stall;
        n_olen     = r_olen;
        n_oovf     = r_oovf;
        o_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = {r_ep, r_sum, r_idx};

        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_addr == TE_M1) begin
                    n_addr  = '0;
                    n_ep    = lsts_pkg::EP_W'(1);
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop      = 1'b1;
                    n_last     = q_item.last;
                    n_idx      = q_item.idx;
                    n_sum      = q_item.sum;
                    n_sum_zero = q_item.sum_zero;
                    n_nprb     = '0;
                    if (q_item.ignore) begin
                        n_ovf   = 1'b1;
                        n_state = q_item.last ? S_OUT : S_IDLE;
                    end else begin
                        if (q_item.rem_zero && (CNT_W'(q_item.idx) + 1'b1 > r_best)) begin
                            n_best = CNT_W'(q_item.idx) + 1'b1;
                        end
                        if (!q_item.rem_zero && q_item.rem_inr) begin
                            n_phase = 1'b0;
                            n_key   = q_item.rem_key;
                            n_addr  = f_hash(q_item.rem_key);
                            n_state = S_PRB;
                        end else if (!q_item.sum_zero) begin
                            n_phase = 1'b1;
                            n_key   = q_item.sum;
                            n_addr  = f_hash(q_item.sum);
                            n_state = S_PRB;
                        end else begin
                            n_state = q_item.last ? S_OUT : S_IDLE;
                        end
                    end
                end
            end
            S_PRB: begin
                ram_re  = 1'b1;
                n_nprb  = r_nprb + 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!r_phase) begin
                    if (rd_hit || !rd_live || (r_nprb == TE_L)) begin
                        if (rd_hit && (cand > r_best)) begin
                            n_best = cand;
                        end
                        if (!r_sum_zero) begin
                            n_phase = 1'b1;
                            n_key   = r_sum;
                            n_addr  = f_hash(r_sum);
                            n_nprb  = '0;
                            n_state = S_PRB;
                        end else begin
                            n_state = r_last ? S_OUT : S_IDLE;
                        end
                    end else begin
                        n_addr  = nxt_addr;
                        n_state = S_PRB;
                    end
                end else begin
                    if (rd_hit) begin
                        n_state = r_last ? S_OUT : S_IDLE;
                    end else if (!rd_live) begin
                        ram_we  = 1'b1;
                        n_state = r_last ? S_OUT : S_IDLE;
                    end else if (r_nprb == TE_L) begin
                        n_ovf   = 1'b1;
                        n_state = r_last ? S_OUT : S_IDLE;
                    end else begin
                        n_addr  = nxt_addr;
                        n_state = S_PRB;
                    end
                end
            end
            S_OUT: begin
                if (!r_oval || !i_out_stall) begin
                    n_oval = 1'b1;
                    n_olen = (best_w > LEN_SAT) ? LEN_SAT[lsts_pkg::LEN_W-1:0]
                                                : best_w[lsts_pkg::LEN_W-1:0];
                    n_oovf = r_ovf;
                    n_best = '0;
                    n_ovf  = 1'b0;
                    n_ep   = r_ep + 1'b1;
                    if (r_ep + 1'b1 == '0) begin
                        n_addr  = '0;
                        n_state = S_CLR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ep    <= '0;
            r_addr  <= '0;
            r_nprb  <= '0;
            r_phase <= 1'b0;
            r_best  <= '0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ep    <= n_ep;
            r_addr  <= n_addr;
            r_nprb  <= n_nprb;
            r_phase <= n_phase;
            r_best  <= n_best;
            r_ovf   <= n_ovf;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_idx      <= n_idx;
        r_sum      <= n_sum;
        r_sum_zero <= n_sum_zero;
        r_key      <= n_key;
        r_olen     <= n_olen;
        r_oovf     <= n_oovf;
    end
endmodule

// File: rtl/longest_subarray_with_target_sum.sv
// Longest contiguous run summing to a target: top level.
// Uses lsts_pkg, lsts_front, lsts_queue and lsts_back (which holds lsts_ram).
//
// Elements stream in with a last marker; on the last word one result gives the longest
// run whose sum equals the target (0 if none) and an overflow flag. The front end takes
// one word per cycle, while the queue is not full, into a two-word queue; the back end
// probes a hashed table of first occurrences held in one RAM, each probe a read state
// (S_PRB) then a check state (S_CHK). A typical word needs one or two short probe chains;
// long collision chains add probes, up to TABLE_ENTRIES probes per lookup. After reset,
// and after every 15 arrays, the back end clears all TABLE_ENTRIES table entries; words
// queue up meanwhile and the input stalls once the queue is full.
module longest_subarray_with_target_sum #(
    parameter int MAX_ELEMENTS  = 1024,
    parameter int TABLE_ENTRIES = 1024,
    parameter int VALUE_BITS    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [VALUE_BITS-1:0] i_element_value,
    input  logic                         i_is_last,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lsts_pkg::LEN_W-1:0]   o_longest_length,
    output logic                         o_overflowed,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic signed [lsts_pkg::TGT_W-1:0] i_cfg_data
);
    localparam int POS_W = $clog2(MAX_ELEMENTS);
    localparam int ENT_W = 5 + POS_W + 2 * (VALUE_BITS + POS_W);
    localparam int LIM   = (MAX_ELEMENTS < 2047) ? MAX_ELEMENTS : 2047;
    localparam logic [lsts_pkg::LEN_W-1:0] LEN_LIM = lsts_pkg::LEN_W'(LIM);

    logic [lsts_pkg::TGT_W-1:0] r_target;
    logic                       q_push, q_pop, q_valid, q_full;
    logic [ENT_W-1:0]           q_wdata, q_rdata;
    logic [1:0]                 q_count;
    lsts_pkg::t_bstat           b_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid) begin
            r_target <= i_cfg_data;
        end
    end

    lsts_front #(.MAX_ELEMENTS(MAX_ELEMENTS), .VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_element_value (i_element_value),
        .i_is_last       (i_is_last),
        .i_target        (r_target),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_push_data     (q_wdata)
    );

    lsts_queue #(.WIDTH(ENT_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_count (q_count)
    );

    lsts_back #(
        .MAX_ELEMENTS  (MAX_ELEMENTS),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .VALUE_BITS    (VALUE_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_data         (q_rdata),
        .o_pop            (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_longest_length (o_longest_length),
        .o_overflowed     (o_overflowed),
        .o_stat           (b_stat)
    );

`ifndef ASSERT_OFF
    a_word_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (q_count != 2'd0))
        else $error("accepted word missing from queue");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count != 2'd3))
        else $error("queue count out of range");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_stat.clearing && $past(b_stat.clearing)) |-> !$rose(o_out_valid))
        else $error("result issued during table clear");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_longest_length <= LEN_LIM))
        else $error("run length above array bound");
`endif
endmodule

// File: verif/testbench.sv
// Testbench for longest_subarray_with_target_sum: random arrays checked against a run tracker.
// Depends on lsts_pkg and the RTL top level; self-checking, no external files.

class run_length_tracker;
    typedef struct {
        logic [lsts_pkg::LEN_W-1:0] length;
        logic                       ovf;
    } t_run_result;

    localparam int MAX_ELEMENTS  = 1024;
    localparam int TABLE_ENTRIES = 1024;

    longint      target;
    longint      prefix_sum;
    int          count;
    int          best;
    bit          ovf;
    int          first_idx[longint];
    t_run_result expected_runs[$];
    int          mismatches;
    int          results_seen;
    int          overflow_runs;

    function new();
        target = 0;
        mismatches = 0;
        results_seen = 0;
        overflow_runs = 0;
        clear_array();
    endfunction

    function void clear_array();
        prefix_sum = 0;
        count = 0;
        best = 0;
        ovf = 0;
        first_idx.delete();
    endfunction

    function void set_target(logic signed [lsts_pkg::TGT_W-1:0] t);
        target = t;
    endfunction

    function void take_element(logic signed [15:0] value, logic last);
        t_run_result r;
        longint      remain;
        int          idx;
        if (count >= MAX_ELEMENTS) begin
            ovf = 1;
        end else begin
            idx = count;
            count++;
            prefix_sum += value;
            remain = prefix_sum - target;
            if (remain == 0) begin
                if (idx + 1 > best) best = idx + 1;
            end else if (first_idx.exists(remain)) begin
                if (idx - first_idx[remain] > best) best = idx - first_idx[remain];
            end
            if (prefix_sum != 0 && !first_idx.exists(prefix_sum)) begin
                if (first_idx.num() < TABLE_ENTRIES) first_idx[prefix_sum] = idx;
                else ovf = 1;
            end
        end
        if (last) begin
            r.length = (best > 2047) ? 11'd2047 : best[10:0];
            r.ovf = ovf;
            if (ovf) overflow_runs++;
            expected_runs.push_back(r);
            clear_array();
        end
    endfunction

    function void check_result(logic [lsts_pkg::LEN_W-1:0] length, logic ovf_out);
        t_run_result e;
        results_seen++;
        if (expected_runs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected word len=%0d ovf=%0b", length, ovf_out);
        end else begin
            e = expected_runs.pop_front();
            if (e.length !== length || e.ovf !== ovf_out) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected len=%0d ovf=%0b got len=%0d ovf=%0b",
                             results_seen, e.length, e.ovf, length, ovf_out);
            end
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                               i_clk = 0;
    logic                               i_rst_n = 0;
    logic                               i_in_valid = 0;
    logic                               o_in_stall;
    logic signed [15:0]                 i_element_value = '0;
    logic                               i_is_last = 0;
    logic                               o_out_valid;
    logic                               i_out_stall = 0;
    logic [lsts_pkg::LEN_W-1:0]         o_longest_length;
    logic                               o_overflowed;
    logic                               i_cfg_valid = 0;
    logic                               o_cfg_ready;
    logic signed [lsts_pkg::TGT_W-1:0]  i_cfg_data = '0;

    run_length_tracker tracker = new();
    bit quiet = 0;
    int elements_sent = 0;
    int arrays_sent = 0;
    int stall_left = 0;
    int gap_left = 0;

    longest_subarray_with_target_sum i_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(o_longest_length, o_overflowed);
        if (quiet || !i_rst_n) begin
            i_out_stall <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= (stall_left != 0);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11);
            i_out_stall <= 1;
        end else begin
            i_out_stall <= 0;
        end
    end

    task automatic send_element(logic signed [15:0] value, logic last);
        if (!quiet && gap_left == 0 && $urandom_range(0, 11) == 0)
            gap_left = $urandom_range(1, 11);
        if (gap_left > 0) begin
            i_in_valid <= 0;
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end
        i_in_valid <= 1;
        i_element_value <= value;
        i_is_last <= last;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_element(value, last);
        elements_sent++;
        if (last) arrays_sent++;
    endtask

    task automatic end_stream();
        i_in_valid <= 0;
    endtask

    task automatic write_target(logic signed [lsts_pkg::TGT_W-1:0] t);
        end_stream();
        wait (tracker.expected_runs.size() == 0);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        tracker.set_target(t);
    endtask

    task automatic send_array(int len, int lo, int hi);
        for (int k = 0; k < len; k++)
            send_element(16'($signed($urandom_range(0, hi - lo)) + lo), k == len - 1);
    endtask

    task automatic send_random_arrays(int n);
        for (int a = 0; a < n; a++) begin
            if ($urandom_range(0, 7) == 0) send_array($urandom_range(1, 12), -32768, 32767);
            else send_array($urandom_range(1, 24), -4, 4);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, single-element hits, zero runs
        send_element(16'sd0, 1);
        send_element(16'sd32767, 0);
        send_element(-16'sd32768, 0);
        send_element(16'sd1, 1);
        send_element(16'sd0, 0);
        send_element(16'sd0, 0);
        send_element(16'sd0, 1);
        send_element(16'sd5, 0);
        send_element(-16'sd5, 0);
        send_element(16'sd3, 1);
        write_target(26'sd5);
        send_element(16'sd5, 1);
        send_element(16'sd2, 0);
        send_element(16'sd3, 0);
        send_element(16'sd9, 0);
        send_element(-16'sd4, 1);
        write_target(-26'sd33554432);
        send_array(6, -32768, -32768);
        write_target(26'sd33554431);
        send_array(6, 32767, 32767);

        // too many elements: one array runs past the length bound
        write_target(26'sd0);
        send_array(1030, -2, 2);

        write_target(-26'sd7);
        send_random_arrays(15);
        write_target(26'sd3);
        send_random_arrays(15);
        write_target($signed(26'($urandom_range(0, 40) - 20)));
        send_random_arrays(15);
        write_target(26'sd0);
        quiet = 1;
        send_random_arrays(20);
        end_stream();

        wait (tracker.expected_runs.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d elements in %0d arrays, %0d results checked, %0d with overflow.",
                 elements_sent, arrays_sent, tracker.results_seen, tracker.overflow_runs);
        $display("Mismatches: %0d", tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.expected_runs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
